// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the block.
// Needs a signal named clk and a signal named rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AST_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/aabbt_pkg.sv =====
// Shared types and constants of the box transform block.
// No dependencies; used by every design module of the block.
package aabbt_pkg;

  localparam int WORD_W    = 32;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX_XY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XZ_YX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY_YZ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZX_ZY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ZZ_TX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TY_TZ = 3'd5;

  // Reset values: identity map, no translation.
  localparam logic [REG_W-1:0] RST_COEF_XX_XY   = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_COEF_XZ_YX   = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_COEF_YY_YZ   = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_COEF_ZX_ZY   = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_COEF_ZZ_TX   = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_OFFSET_TY_TZ = 64'h0000_0000_0000_0000;

  typedef logic signed [WORD_W-1:0] word_t;

  // Matrix a[row][col] and translation t[row], raw 32-bit register halves.
  typedef struct packed {
    word_t [2:0][2:0] a;
    word_t [2:0]      t;
  } xform_t;

  // One box: lower corner in lo, upper corner in hi, index 0 is x.
  typedef struct packed {
    logic        last;
    word_t [2:0] hi;
    word_t [2:0] lo;
  } box_t;

  // Control that travels with the data between pipeline sections.
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

// ===== hdl/aabbt_cfg_regs.sv =====
// Configuration register file of the box transform block.
// Depends on aabbt_pkg for register indexes, reset values and xform_t.
module aabbt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aabbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aabbt_pkg::REG_W-1:0]        cfg_data,
  output aabbt_pkg::xform_t                  xform
);

  logic [aabbt_pkg::REG_W-1:0] coef_xx_xy;
  logic [aabbt_pkg::REG_W-1:0] coef_xz_yx;
  logic [aabbt_pkg::REG_W-1:0] coef_yy_yz;
  logic [aabbt_pkg::REG_W-1:0] coef_zx_zy;
  logic [aabbt_pkg::REG_W-1:0] coef_zz_tx;
  logic [aabbt_pkg::REG_W-1:0] offset_ty_tz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx_xy   <= aabbt_pkg::RST_COEF_XX_XY;
      coef_xz_yx   <= aabbt_pkg::RST_COEF_XZ_YX;
      coef_yy_yz   <= aabbt_pkg::RST_COEF_YY_YZ;
      coef_zx_zy   <= aabbt_pkg::RST_COEF_ZX_ZY;
      coef_zz_tx   <= aabbt_pkg::RST_COEF_ZZ_TX;
      offset_ty_tz <= aabbt_pkg::RST_OFFSET_TY_TZ;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aabbt_pkg::REG_COEF_XX_XY:   coef_xx_xy   <= cfg_data;
        aabbt_pkg::REG_COEF_XZ_YX:   coef_xz_yx   <= cfg_data;
        aabbt_pkg::REG_COEF_YY_YZ:   coef_yy_yz   <= cfg_data;
        aabbt_pkg::REG_COEF_ZX_ZY:   coef_zx_zy   <= cfg_data;
        aabbt_pkg::REG_COEF_ZZ_TX:   coef_zz_tx   <= cfg_data;
        aabbt_pkg::REG_OFFSET_TY_TZ: offset_ty_tz <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    xform.a[0][0] = coef_xx_xy[31:0];
    xform.a[0][1] = coef_xx_xy[63:32];
    xform.a[0][2] = coef_xz_yx[31:0];
    xform.a[1][0] = coef_xz_yx[63:32];
    xform.a[1][1] = coef_yy_yz[31:0];
    xform.a[1][2] = coef_yy_yz[63:32];
    xform.a[2][0] = coef_zx_zy[31:0];
    xform.a[2][1] = coef_zx_zy[63:32];
    xform.a[2][2] = coef_zz_tx[31:0];
    xform.t[0]    = coef_zz_tx[63:32];
    xform.t[1]    = offset_ty_tz[31:0];
    xform.t[2]    = offset_ty_tz[63:32];
  end

endmodule

// ===== hdl/aabbt_corner_mul.sv =====
// Input register and product stage: every coefficient times both corners.
// Depends on aabbt_pkg for box_t, xform_t and pipe_ctl_t.
module aabbt_corner_mul #(
  parameter int COORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  aabbt_pkg::box_t                       in_box,
  input  aabbt_pkg::xform_t                     xform,
  output aabbt_pkg::pipe_ctl_t                  out_ctl,
  input  logic                                  out_ready,
  output logic [2:0][2:0][2*COORD_BITS-1:0]     prod_lo,
  output logic [2:0][2:0][2*COORD_BITS-1:0]     prod_hi
);

  localparam int PROD_W = 2 * COORD_BITS;

  aabbt_pkg::pipe_ctl_t             ctl1;
  logic [2:0][COORD_BITS-1:0]       lo1;
  logic [2:0][COORD_BITS-1:0]       hi1;
  logic [2:0][2:0][COORD_BITS-1:0]  coef;
  logic                             en1;
  logic                             en2;

  // A stage loads when empty or when its contents move on.
  assign en2      = !out_ctl.valid || out_ready;
  assign en1      = !ctl1.valid || en2;
  assign in_ready = en1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = xform.a[r][c][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (en1) ctl1.valid    <= in_valid;
      if (en2) out_ctl.valid <= ctl1.valid;
    end
  end

  // Keep only the low COORD_BITS of each coordinate.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ctl1.last <= in_box.last;
      for (int c = 0; c < 3; c++) begin
        lo1[c] <= in_box.lo[c][COORD_BITS-1:0];
        hi1[c] <= in_box.hi[c][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && ctl1.valid) begin
      out_ctl.last <= ctl1.last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_lo[r][c] <= PROD_W'($signed(coef[r][c]) * $signed(lo1[c]));
          prod_hi[r][c] <= PROD_W'($signed(coef[r][c]) * $signed(hi1[c]));
        end
      end
    end
  end

endmodule

// ===== hdl/aabbt_bound_sum.sv =====
// Bound stages: per-column min/max of scaled products, sums, saturation.
// Depends on aabbt_pkg for box_t, xform_t and pipe_ctl_t.
module aabbt_bound_sum #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  aabbt_pkg::pipe_ctl_t                  in_ctl,
  output logic                                  in_ready,
  input  logic [2:0][2:0][2*COORD_BITS-1:0]     prod_lo,
  input  logic [2:0][2:0][2*COORD_BITS-1:0]     prod_hi,
  input  aabbt_pkg::xform_t                     xform,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output aabbt_pkg::box_t                       out_box
);

  localparam int WW     = aabbt_pkg::WORD_W;
  localparam int PW     = 2 * COORD_BITS - FRAC_BITS;
  localparam int AW     = (PW > COORD_BITS) ? PW : COORD_BITS;
  localparam int HW     = AW + 1;
  localparam int SW     = AW + 2;
  localparam logic signed [SW-1:0] SAT_HI =
    SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO =
    SW'(-(64'sd1 <<< (COORD_BITS - 1)));

  aabbt_pkg::pipe_ctl_t        ctl3;
  aabbt_pkg::pipe_ctl_t        ctl4;
  logic signed [PW-1:0]        mn3 [3][3];
  logic signed [PW-1:0]        mx3 [3][3];
  logic signed [HW-1:0]        sa_mn [3];
  logic signed [HW-1:0]        sb_mn [3];
  logic signed [HW-1:0]        sa_mx [3];
  logic signed [HW-1:0]        sb_mx [3];
  logic signed [PW-1:0]        sh_lo [3][3];
  logic signed [PW-1:0]        sh_hi [3][3];
  logic signed [COORD_BITS-1:0] t_s [3];
  aabbt_pkg::box_t             box_next;
  logic                        en3;
  logic                        en4;
  logic                        en5;

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = s;
    if (s > SAT_HI) v = SAT_HI;
    if (s < SAT_LO) v = SAT_LO;
    return v[COORD_BITS-1:0];
  endfunction

  assign en5      = !out_valid || out_ready;
  assign en4      = !ctl4.valid || en5;
  assign en3      = !ctl3.valid || en4;
  assign in_ready = en3;

  // Arithmetic shift floors, so the scaled value always fits in PW bits.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      t_s[r] = xform.t[r][COORD_BITS-1:0];
      for (int c = 0; c < 3; c++) begin
        sh_lo[r][c] = PW'($signed(prod_lo[r][c]) >>> FRAC_BITS);
        sh_hi[r][c] = PW'($signed(prod_hi[r][c]) >>> FRAC_BITS);
      end
    end
  end

  always_comb begin
    box_next.last = ctl4.last;
    for (int r = 0; r < 3; r++) begin
      box_next.lo[r] = WW'(sat(SW'(sa_mn[r]) + SW'(sb_mn[r])));
      box_next.hi[r] = WW'(sat(SW'(sa_mx[r]) + SW'(sb_mx[r])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
      ctl4.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (en3) ctl3.valid <= in_ctl.valid;
      if (en4) ctl4.valid <= ctl3.valid;
      if (en5) out_valid  <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_ctl.valid) begin
      ctl3.last <= in_ctl.last;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (sh_lo[r][c] < sh_hi[r][c]) begin
            mn3[r][c] <= sh_lo[r][c];
            mx3[r][c] <= sh_hi[r][c];
          end else begin
            mn3[r][c] <= sh_hi[r][c];
            mx3[r][c] <= sh_lo[r][c];
          end
        end
      end
    end
  end

  // Split each four-term sum into two pairs.
  always_ff @(posedge clk) begin
    if (en4 && ctl3.valid) begin
      ctl4.last <= ctl3.last;
      for (int r = 0; r < 3; r++) begin
        sa_mn[r] <= HW'(t_s[r]) + HW'(mn3[r][0]);
        sb_mn[r] <= HW'(mn3[r][1]) + HW'(mn3[r][2]);
        sa_mx[r] <= HW'(t_s[r]) + HW'(mx3[r][0]);
        sb_mx[r] <= HW'(mx3[r][1]) + HW'(mx3[r][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && ctl4.valid) begin
      out_box <= box_next;
    end
  end

endmodule

// ===== hdl/aabb_affine_transform_top.sv =====
// Top level of the affine bounding-box transform.
// Depends on aabbt_pkg, aabbt_cfg_regs, aabbt_corner_mul and aabbt_bound_sum.
//
// Maps each input box through a 3x3 matrix plus translation and returns the
// axis-aligned box bounding the eight mapped corners, saturated per axis.
// The pipeline takes one box every cycle while the output side does not
// stall; the stage depth is set by the second stage, which holds eighteen
// COORD_BITS by COORD_BITS signed multipliers. Backpressure propagates stage
// by stage, so empty stages fill while the output waits. The user must write
// registers through the cfg port only while no box is in flight; the block
// itself does not enforce this.
module aabb_affine_transform_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  input  logic [191:0]                      s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [191:0]                      m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aabbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aabbt_pkg::REG_W-1:0]       cfg_data
);

  aabbt_pkg::xform_t                    xform;
  aabbt_pkg::box_t                      in_box;
  aabbt_pkg::box_t                      out_box;
  aabbt_pkg::pipe_ctl_t                 mul_ctl;
  logic                                 mul_ready;
  logic [2:0][2:0][2*COORD_BITS-1:0]    prod_lo;
  logic [2:0][2:0][2*COORD_BITS-1:0]    prod_hi;

  assign in_box                       = {s_axis_tlast, s_axis_tdata};
  assign {m_axis_tlast, m_axis_tdata} = out_box;

  aabbt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .xform     (xform)
  );

  aabbt_corner_mul #(
    .COORD_BITS (COORD_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_box    (in_box),
    .xform     (xform),
    .out_ctl   (mul_ctl),
    .out_ready (mul_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi)
  );

  aabbt_bound_sum #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mul_ctl),
    .in_ready  (mul_ready),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .xform     (xform),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_box   (out_box)
  );

endmodule

// ===== hdl/aabbt_port_checker.sv =====
// Port-level checks of the box transform top level, bound to it below.
// Depends on assert_macros.svh and on the top level's port names.
`include "assert_macros.svh"

module aabbt_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled result must hold until its transfer.
  `AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Lower bound never exceeds upper bound on any axis.
  `AST_IMPLY(a_order_x, m_axis_tvalid, $signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[127:96]), "x bounds out of order")
  `AST_IMPLY(a_order_y, m_axis_tvalid, $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[159:128]), "y bounds out of order")
  `AST_IMPLY(a_order_z, m_axis_tvalid, $signed(m_axis_tdata[95:64]) <= $signed(m_axis_tdata[191:160]), "z bounds out of order")

  // With the sink ready every stage advances, so the input side is open.
  `AST_IMPLY(a_ready_flow, m_axis_tready, s_axis_tready, "input blocked while output ready")

endmodule

bind aabb_affine_transform_top aabbt_port_checker u_port_checker (.*);
